// ----- design/pdpf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pdpf_pkg;

    // Fixed field widths of the item and result channels.
    localparam int NODE_W      = 6;
    localparam int IN_VALUE_W  = 16;
    localparam int CAP_W       = 16;
    localparam int NREQ_W      = 5;
    localparam int TABLE_DEPTH = 64;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // Defaults for the top level parameters.
    localparam int DEF_MAX_PATH    = 7;
    localparam int DEF_VALUE_WIDTH = 16;

    localparam logic [NREQ_W-1:0] NUM_REQUESTS_RESET     = 5'd31;
    localparam logic [CAP_W-1:0]  VEHICLE_CAPACITY_RESET = 16'hFFFF;

    // Item kinds carried in tuser.
    localparam logic OP_TABLE = 1'b0;
    localparam logic OP_PATH  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_REQUESTS     = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VEHICLE_CAPACITY = 1'd1;

    typedef enum logic [1:0] {
        ST_FEASIBLE   = 2'd0,
        ST_INFEASIBLE = 2'd1,
        ST_BAD_LENGTH = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept_en;
        logic    walk_clr;
        logic    i_inc;
        logic    i_clr;
        logic    sel_sim;
        logic    pre_add;
        logic    sim_add;
        logic    res_load;
        status_t res_code;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_done;
        logic bad_len;
        logic i_done;
        logic deliv;
        logic after_hit;
        logic before_hit;
        logic over;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- design/pdpf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pdpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/pdpf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pdpf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pdpf_pkg::dp_status_t sts,
    output pdpf_pkg::dp_cmd_t        cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_START    = 8'b0000_0010,
        S_PRE_REQ  = 8'b0000_0100,
        S_PRE_ADD  = 8'b0000_1000,
        S_SIM_REQ  = 8'b0001_0000,
        S_SIM_CHK1 = 8'b0010_0000,
        S_SIM_CHK2 = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    pdpf_pkg::status_t code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= pdpf_pkg::ST_FEASIBLE;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        code_next    = code_reg;
        cmd          = '0;
        cmd.res_code = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept_en = 1'b1;
                if (sts.last_done)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (sts.bad_len)
                begin
                    code_next  = pdpf_pkg::ST_BAD_LENGTH;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.walk_clr = 1'b1;
                    state_next   = S_PRE_REQ;
                end
            end
            // Pickup pass: precedence check and start load.
            S_PRE_REQ:
            begin
                if (sts.i_done)
                begin
                    cmd.i_clr  = 1'b1;
                    state_next = S_SIM_REQ;
                end
                else if (sts.deliv && sts.after_hit)
                begin
                    code_next  = pdpf_pkg::ST_INFEASIBLE;
                    state_next = S_RESULT;
                end
                else if (sts.deliv && !sts.before_hit)
                begin
                    state_next = S_PRE_ADD;
                end
                else
                begin
                    cmd.i_inc = 1'b1;
                end
            end
            S_PRE_ADD:
            begin
                cmd.pre_add = 1'b1;
                cmd.i_inc   = 1'b1;
                state_next  = S_PRE_REQ;
            end
            // Load simulation along the path.
            S_SIM_REQ:
            begin
                cmd.sel_sim = 1'b1;
                if (sts.i_done)
                begin
                    code_next  = pdpf_pkg::ST_FEASIBLE;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SIM_CHK1;
                end
            end
            S_SIM_CHK1:
            begin
                cmd.sel_sim = 1'b1;
                if (sts.over)
                begin
                    code_next  = pdpf_pkg::ST_INFEASIBLE;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.sim_add = 1'b1;
                    state_next  = S_SIM_CHK2;
                end
            end
            S_SIM_CHK2:
            begin
                cmd.sel_sim = 1'b1;
                if (sts.over)
                begin
                    code_next  = pdpf_pkg::ST_INFEASIBLE;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_SIM_REQ;
                end
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/pdpf_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pdpf_datapath #(
    parameter int MAX_PATH    = pdpf_pkg::DEF_MAX_PATH,
    parameter int VALUE_WIDTH = pdpf_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pdpf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [pdpf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    input  wire logic [pdpf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tlast,
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [pdpf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire pdpf_pkg::dp_cmd_t                cmd,
    output pdpf_pkg::dp_status_t                  sts
);

    localparam int CNT_W   = $clog2(MAX_PATH + 1);
    localparam int IDX_W   = $clog2(MAX_PATH);
    localparam int NODE_W  = pdpf_pkg::NODE_W;
    localparam int ADDR_W  = $clog2(pdpf_pkg::TABLE_DEPTH);
    localparam int WIDE_W  = (VALUE_WIDTH > pdpf_pkg::CAP_W) ? VALUE_WIDTH : pdpf_pkg::CAP_W;
    localparam int LOAD_W  = WIDE_W + $clog2(2 * MAX_PATH) + 2;
    localparam int ENTRY_W = 2 * VALUE_WIDTH;

    // Configuration registers.
    logic [pdpf_pkg::NREQ_W-1:0] nreq_reg;
    logic [pdpf_pkg::CAP_W-1:0]  cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nreq_reg <= pdpf_pkg::NUM_REQUESTS_RESET;
            cap_reg  <= pdpf_pkg::VEHICLE_CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pdpf_pkg::CFG_NUM_REQUESTS:
                begin
                    nreq_reg <= cfg_wdata[pdpf_pkg::NREQ_W-1:0];
                end
                pdpf_pkg::CFG_VEHICLE_CAPACITY:
                begin
                    cap_reg <= cfg_wdata[pdpf_pkg::CAP_W-1:0];
                end
                default:
                begin
                    nreq_reg <= nreq_reg;
                end
            endcase
        end
    end

    // Input item fields.
    logic [NODE_W-1:0]               in_node;
    logic [pdpf_pkg::IN_VALUE_W-1:0] in_demand;
    logic [pdpf_pkg::IN_VALUE_W-1:0] in_draught;
    logic                            accept;
    logic [31:0]                     demand_ext;
    logic [31:0]                     draught_ext;

    assign in_node     = s_axis_tdata[5:0];
    assign in_demand   = s_axis_tdata[21:6];
    assign in_draught  = s_axis_tdata[37:22];
    assign accept      = s_axis_tvalid && cmd.accept_en;
    assign demand_ext  = {{16{in_demand[15]}}, in_demand};
    assign draught_ext = {16'd0, in_draught};

    // Node table: draught in the upper half, demand in the lower half.
    logic                 tbl_we;
    logic [ADDR_W-1:0]    tbl_raddr;
    logic [ENTRY_W-1:0]   tbl_wdata;
    logic [ENTRY_W-1:0]   tbl_rdata;

    assign tbl_we    = accept && (s_axis_tuser == pdpf_pkg::OP_TABLE);
    assign tbl_wdata = {draught_ext[VALUE_WIDTH-1:0], demand_ext[VALUE_WIDTH-1:0]};

    pdpf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (pdpf_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (in_node),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Path store.
    logic [NODE_W-1:0] store_reg [MAX_PATH];
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic              path_acc;

    assign path_acc = accept && (s_axis_tuser == pdpf_pkg::OP_PATH);

    always_ff @(posedge clk)
    begin
        if (path_acc && (count_reg < CNT_W'(MAX_PATH)))
        begin
            store_reg[count_reg[IDX_W-1:0]] <= in_node;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (path_acc)
        begin
            if (count_reg < CNT_W'(MAX_PATH))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Walk position and load.
    logic [CNT_W-1:0]         i_reg;
    logic signed [LOAD_W-1:0] load_reg;
    logic signed [LOAD_W-1:0] rd_demand;
    logic signed [LOAD_W-1:0] rd_draught;
    logic signed [LOAD_W-1:0] cap_ext;

    assign rd_demand  = {{(LOAD_W-VALUE_WIDTH){tbl_rdata[VALUE_WIDTH-1]}},
                         tbl_rdata[VALUE_WIDTH-1:0]};
    assign rd_draught = {{(LOAD_W-VALUE_WIDTH){1'b0}}, tbl_rdata[ENTRY_W-1:VALUE_WIDTH]};
    assign cap_ext    = {{(LOAD_W-pdpf_pkg::CAP_W){1'b0}}, cap_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            load_reg <= '0;
        end
        else
        begin
            if (cmd.walk_clr || cmd.i_clr)
            begin
                i_reg <= '0;
            end
            else if (cmd.i_inc)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.walk_clr)
            begin
                load_reg <= '0;
            end
            else if (cmd.pre_add || cmd.sim_add)
            begin
                load_reg <= load_reg + rd_demand;
            end
        end
    end

    // Node at the walk position and its pickup, if it is a delivery.
    logic [NODE_W-1:0] walk_node;
    logic [NODE_W-1:0] pick_node;
    logic [NODE_W:0]   n_ext;
    logic              deliv;
    logic              after_hit;
    logic              before_hit;

    assign walk_node = (i_reg < CNT_W'(MAX_PATH)) ? store_reg[i_reg[IDX_W-1:0]] : '0;
    assign n_ext     = {2'b00, nreq_reg};
    assign deliv     = ({1'b0, walk_node} >= n_ext + 1'b1) &&
                       ({1'b0, walk_node} <= {1'b0, nreq_reg, 1'b0});
    assign pick_node = walk_node - n_ext[NODE_W-1:0];
    assign tbl_raddr = cmd.sel_sim ? walk_node : pick_node;

    always_comb
    begin
        after_hit  = 1'b0;
        before_hit = 1'b0;
        for (int k = 0; k < MAX_PATH; k++)
        begin
            if ((CNT_W'(k) < count_reg) && (store_reg[k] == pick_node))
            begin
                if (CNT_W'(k) > i_reg)
                begin
                    after_hit = 1'b1;
                end
                if (CNT_W'(k) < i_reg)
                begin
                    before_hit = 1'b1;
                end
            end
        end
    end

    // Result register.
    logic                out_valid_reg;
    pdpf_pkg::status_t   out_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_code_reg <= cmd.res_code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(pdpf_pkg::M_TDATA_W-2){1'b0}}, out_code_reg};

    assign sts.last_done  = path_acc && s_axis_tlast;
    assign sts.bad_len    = ovf_reg || (count_reg == CNT_W'(2));
    assign sts.i_done     = (i_reg == count_reg);
    assign sts.deliv      = deliv;
    assign sts.after_hit  = after_hit;
    assign sts.before_hit = before_hit;
    assign sts.over       = (load_reg > rd_draught) || (load_reg > cap_ext);
    assign sts.out_busy   = out_valid_reg && !m_axis_tready;

endmodule

`default_nettype wire

// ----- design/pickup_delivery_path_feasibility_top.sv -----
// Pickup-delivery path feasibility checker. Items with tuser low write the demand and
// draught of one node into a 64-entry table; items with tuser high append a path node,
// and both kinds are taken back to back. The path node with tlast set starts the check,
// which returns one status item: 0 feasible, 1 infeasible, 2 for a path of two nodes
// or one longer than MAX_PATH. The check walks the stored path through the single
// read port of the node table: a first pass over the nodes for precedence and the
// starting load, then a load simulation along the path; a failing path ends the
// check early. No item is taken during the check; a pending result does not block
// items, but the result of the next check waits for it to be taken.
`timescale 1ns / 1ps
`default_nettype none

module pickup_delivery_path_feasibility_top #(
    parameter int MAX_PATH    = pdpf_pkg::DEF_MAX_PATH,
    parameter int VALUE_WIDTH = pdpf_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pdpf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [pdpf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // node [5:0], entry_demand [21:6], entry_draught [37:22], zero fill [39:38]
    input  wire logic [pdpf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tlast,
    // op [0]
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // status [1:0], zero fill [7:2]
    output logic      [pdpf_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    pdpf_pkg::dp_cmd_t    cmd;
    pdpf_pkg::dp_status_t sts;

    assign s_axis_tready = cmd.accept_en;

    pdpf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pdpf_datapath #(
        .MAX_PATH    (MAX_PATH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire

// ----- design/pdpf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pdpf_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           s_axis_tlast,
    input wire logic                           s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [pdpf_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A held result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Only the three defined status codes leave the block, with zero fill above.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[7:2] == 6'd0))
        else $error("undefined status code");

    // The final node of a path starts the check, so input stops for a while.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == pdpf_pkg::OP_PATH) && s_axis_tlast
        |=> !s_axis_tready)
        else $error("input still open after the final path node");

    // Table writes and inner path nodes keep the input open.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
        !((s_axis_tuser == pdpf_pkg::OP_PATH) && s_axis_tlast)
        |=> s_axis_tready)
        else $error("input closed after an item that starts no check");

endmodule

bind pickup_delivery_path_feasibility_top pdpf_checker u_pdpf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/pickup_delivery_path_feasibility_top_tb.sv -----
`timescale 1ns / 1ps

module pickup_delivery_path_feasibility_top_tb;

    localparam int ROUTE_MAX     = pdpf_pkg::DEF_MAX_PATH;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic               op;
        logic [5:0]         node;
        logic signed [15:0] demand;
        logic [15:0]        draught;
        logic               last;
        bit                 drain;
    } hop_t;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            cfg_we        = 1'b0;
    logic [pdpf_pkg::CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [pdpf_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [pdpf_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            s_axis_tlast  = 1'b0;
    logic                            s_axis_tuser  = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [pdpf_pkg::M_TDATA_W-1:0]  m_axis_tdata;

    // Shadow copy of the block's tables, path buffer and registers.
    logic signed [15:0]          node_demand [pdpf_pkg::TABLE_DEPTH];
    logic [15:0]                 node_draught [pdpf_pkg::TABLE_DEPTH];
    logic [5:0]                  route [ROUTE_MAX];
    int                          route_len = 0;
    bit                          route_ovf = 1'b0;
    logic [pdpf_pkg::NREQ_W-1:0] pair_cnt  = pdpf_pkg::NUM_REQUESTS_RESET;
    logic [pdpf_pkg::CAP_W-1:0]  cap_lim   = pdpf_pkg::VEHICLE_CAPACITY_RESET;

    pdpf_pkg::status_t verdict_q [$];
    hop_t              feed_q [$];
    logic [5:0]        route_buf [$];
    hop_t              cur_hop;
    pdpf_pkg::status_t want;

    int gap_left     = 0;
    int rx_wait      = 0;
    int mismatches   = 0;
    int results_seen = 0;
    int item_total   = 0;
    int stall_left   = 0;
    int stalls_done  = 0;
    bit burst_mode   = 1'b0;
    bit long_stall   = 1'b0;
    bit route_open   = 1'b0;

    pickup_delivery_path_feasibility_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit over_limit(longint load, logic [5:0] nd);
        return load > longint'(node_draught[nd]) || load > longint'(cap_lim);
    endfunction

    function automatic pdpf_pkg::status_t judge_route();
        int unsigned n;
        longint      load;
        bit          seen;
        logic [5:0]  d;
        logic [5:0]  p;
        n = pair_cnt;
        load = 0;
        if (route_ovf || route_len == 2)
            return pdpf_pkg::ST_BAD_LENGTH;
        for (int i = 0; i < route_len; i++)
        begin
            d = route[i];
            if (d >= n + 1 && d <= 2 * n)
            begin
                p = 6'(d - n);
                seen = 1'b0;
                for (int j = i + 1; j < route_len; j++)
                    if (route[j] == p)
                        return pdpf_pkg::ST_INFEASIBLE;
                for (int j = 0; j < i; j++)
                    if (route[j] == p)
                        seen = 1'b1;
                // A delivery without its pickup earlier starts out carrying that load.
                if (!seen)
                    load += longint'(node_demand[p]);
            end
        end
        for (int i = 0; i < route_len; i++)
        begin
            if (over_limit(load, route[i]))
                return pdpf_pkg::ST_INFEASIBLE;
            load += longint'(node_demand[route[i]]);
            if (over_limit(load, route[i]))
                return pdpf_pkg::ST_INFEASIBLE;
        end
        return pdpf_pkg::ST_FEASIBLE;
    endfunction

    function automatic void absorb_item(hop_t h);
        if (h.op == pdpf_pkg::OP_TABLE)
        begin
            node_demand[h.node]  = h.demand;
            node_draught[h.node] = h.draught;
        end
        else
        begin
            if (route_len < ROUTE_MAX)
            begin
                route[route_len] = h.node;
                route_len++;
            end
            else
                route_ovf = 1'b1;
            if (h.last)
            begin
                verdict_q = {verdict_q, judge_route()};
                route_len = 0;
                route_ovf = 1'b0;
            end
        end
    endfunction

    function automatic int idle_draw();
        return burst_mode ? 0 : $urandom_range(0, 6);
    endfunction

    // Sender: one item at a time from feed_q, with a random gap after each accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_item(cur_hop);
                gap_left = idle_draw();
            end
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    // A drain mark holds the sender until every status has come back.
                    while (feed_q.size() > 0 && feed_q[0].drain && verdict_q.size() == 0)
                        feed_q.delete(0);
                    if (feed_q.size() > 0 && !feed_q[0].drain)
                    begin
                        cur_hop = feed_q.pop_front();
                        s_axis_tvalid <= 1'b1;
                        s_axis_tuser  <= cur_hop.op;
                        s_axis_tlast  <= cur_hop.last;
                        s_axis_tdata  <= {2'b00, cur_hop.draught, cur_hop.demand, cur_hop.node};
                    end
                    else
                        s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each status item and draws a random wait after it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("status: no item expected, actual %0d", m_axis_tdata[1:0]);
                    mismatches++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_axis_tdata[1:0] !== want)
                    begin
                        $error("status: expected %0d, actual %0d", want, m_axis_tdata[1:0]);
                        mismatches++;
                    end
                end
                results_seen <= results_seen + 1;
                rx_wait = idle_draw();
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= !long_stall;
        end
    end

    // Two long receiver stalls so that a finished check backs up into the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left  <= 0;
            long_stall  <= 1'b0;
            stalls_done <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            long_stall <= (stall_left > 1);
        end
        else if (stalls_done < 2 && results_seen == 25 + 100 * stalls_done)
        begin
            stall_left  <= 300;
            long_stall  <= 1'b1;
            stalls_done <= stalls_done + 1;
        end
    end

    task automatic put_entry(input logic [5:0] nd, input logic signed [15:0] dem,
                             input logic [15:0] dra, input logic lst);
        hop_t h;
        h.op      = pdpf_pkg::OP_TABLE;
        h.node    = nd;
        h.demand  = dem;
        h.draught = dra;
        h.last    = lst;
        h.drain   = 1'b0;
        feed_q = {feed_q, h};
        item_total++;
    endtask

    task automatic put_hop(input logic [5:0] nd, input logic lst);
        hop_t h;
        h.op      = pdpf_pkg::OP_PATH;
        h.node    = nd;
        h.demand  = 16'($urandom);
        h.draught = 16'($urandom);
        h.last    = lst;
        h.drain   = 1'b0;
        feed_q = {feed_q, h};
        item_total++;
        route_open = !lst;
    endtask

    task automatic put_drain();
        hop_t h;
        h.op      = pdpf_pkg::OP_TABLE;
        h.node    = '0;
        h.demand  = '0;
        h.draught = '0;
        h.last    = 1'b0;
        h.drain   = 1'b1;
        feed_q = {feed_q, h};
    endtask

    task automatic flush_route();
        for (int i = 0; i < route_buf.size(); i++)
            put_hop(route_buf[i], i == route_buf.size() - 1);
        route_buf.delete();
    endtask

    // Pickups mostly precede their deliveries; some deliveries lack a pickup, and a
    // random swap now and then breaks the order.
    task automatic build_route(input int len);
        int         pending_pk [$];
        int         n;
        int         r;
        int         k;
        int         a;
        int         b;
        logic [5:0] t;
        n = pair_cnt;
        route_buf.delete();
        while (route_buf.size() < len)
        begin
            r = $urandom_range(0, 9);
            if (n > 0 && r < 4)
            begin
                k = $urandom_range(1, n);
                pending_pk = {pending_pk, k};
                route_buf = {route_buf, 6'(k)};
            end
            else if (r < 8 && pending_pk.size() > 0)
            begin
                k = $urandom_range(0, pending_pk.size() - 1);
                route_buf = {route_buf, 6'(pending_pk[k] + n)};
                pending_pk.delete(k);
            end
            else if (n > 0 && r == 8)
                route_buf = {route_buf, 6'($urandom_range(n + 1, 2 * n))};
            else if ($urandom_range(0, 1) == 0)
                route_buf = {route_buf, 6'd0};
            else
                route_buf = {route_buf, 6'($urandom_range(2 * n + 1, 63))};
        end
        if (len > 1 && $urandom_range(0, 4) == 0)
        begin
            a = $urandom_range(0, len - 1);
            b = $urandom_range(0, len - 1);
            t = route_buf[a];
            route_buf[a] = route_buf[b];
            route_buf[b] = t;
        end
        flush_route();
    endtask

    task automatic put_sane_entry();
        int         v;
        logic [5:0] nd;
        nd = 6'($urandom_range(0, 63));
        if (nd >= 1 && nd <= pair_cnt)
            v = $urandom_range(0, 4000);
        else if (nd > pair_cnt && nd <= 2 * pair_cnt)
            v = -$urandom_range(0, 4000);
        else
            v = $urandom_range(0, 400) - 200;
        put_entry(nd, 16'(v),
                  ($urandom_range(0, 3) != 0) ? 16'hFFFF : 16'($urandom_range(2000, 65535)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic put_noise();
        if ($urandom_range(0, 1) == 0)
            put_entry(6'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        else
            put_hop(6'($urandom), $urandom_range(0, 3) == 0);
    endtask

    // Checked at the falling edge so that no pending driver update is missed.
    task automatic wait_quiet();
        @(negedge clk);
        while (feed_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [pdpf_pkg::NREQ_W-1:0] n,
                                input logic [pdpf_pkg::CAP_W-1:0] cap);
        wait_quiet();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= pdpf_pkg::CFG_NUM_REQUESTS;
        cfg_wdata <= {{(pdpf_pkg::CFG_DATA_W - pdpf_pkg::NREQ_W){1'b0}}, n};
        @(posedge clk);
        cfg_addr  <= pdpf_pkg::CFG_VEHICLE_CAPACITY;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pair_cnt = n;
        cap_lim  = cap;
    endtask

    initial
    begin
        int                          v;
        int                          len;
        logic [pdpf_pkg::NREQ_W-1:0] n;
        logic [pdpf_pkg::CAP_W-1:0]  cap;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        program_regs(pdpf_pkg::NUM_REQUESTS_RESET, pdpf_pkg::VEHICLE_CAPACITY_RESET);

        // Every table entry holds a value before any path can read it.
        for (int i = 0; i < pdpf_pkg::TABLE_DEPTH; i++)
        begin
            v = $urandom_range(0, 40);
            put_entry(6'(i), 16'(v - 20), 16'hFFFF, 1'b0);
        end

        put_entry(6'd0, -16'sd32768, 16'd0, 1'b1);
        put_entry(6'd63, 16'sd32767, 16'hFFFF, 1'b0);
        put_hop(6'd5, 1'b1);
        put_hop(6'd3, 1'b0);
        put_hop(6'd34, 1'b1);
        put_hop(6'd32, 1'b0);
        put_hop(6'd1, 1'b0);
        put_hop(6'd4, 1'b1);
        // Delivery 40 has no pickup on the path, and two visits to node 63 then bring
        // the load up to about the largest capacity without wrapping.
        put_hop(6'd40, 1'b0);
        put_hop(6'd63, 1'b0);
        put_hop(6'd63, 1'b1);
        put_drain();
        for (int i = 1; i <= 8; i++)
            put_hop(6'(i), i == 8);
        put_hop(6'd1, 1'b0);
        put_hop(6'd2, 1'b0);
        put_hop(6'd3, 1'b0);
        put_hop(6'd32, 1'b0);
        put_hop(6'd33, 1'b0);
        put_hop(6'd34, 1'b0);
        put_hop(6'd62, 1'b1);

        // With no pairs every node is a plain node.
        program_regs('0, '0);
        put_hop(6'd40, 1'b0);
        put_hop(6'd9, 1'b0);
        put_hop(6'd0, 1'b1);

        while (item_total < 1050)
        begin
            case ($urandom_range(0, 5))
                0: n = '0;
                1: n = 5'd1;
                2: n = 5'd31;
                default: n = 5'($urandom_range(1, 31));
            endcase
            case ($urandom_range(0, 5))
                0: cap = '0;
                1: cap = 16'hFFFF;
                default: cap = 16'($urandom_range(8000, 65535));
            endcase
            if (route_open)
                put_hop(6'd0, 1'b1);
            program_regs(n, cap);
            burst_mode = ($urandom_range(0, 3) == 0);
            repeat (8) put_sane_entry();
            repeat ($urandom_range(4, 8))
            begin
                case ($urandom_range(0, 19))
                    0: repeat (3) put_noise();
                    1: build_route(2);
                    2: build_route($urandom_range(8, 12));
                    default:
                    begin
                        len = $urandom_range(1, 7);
                        build_route((len == 2) ? 3 : len);
                    end
                endcase
                if ($urandom_range(0, 9) == 0)
                    put_drain();
            end
        end
        if (route_open)
            put_hop(6'd0, 1'b1);

        wait_quiet();
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/pdpf_pkg.sv
design/pdpf_ram.sv
design/pdpf_ctrl.sv
design/pdpf_datapath.sv
design/pickup_delivery_path_feasibility_top.sv
design/pdpf_checker.sv
tb/pickup_delivery_path_feasibility_top_tb.sv
